/* sv/lzd_pkg.sv */
package lzd_pkg;

  localparam int unsigned WIN_SIZE = 1024;
  localparam int unsigned WIN_AW = 10;
  localparam int unsigned FILL_W = 11;
  localparam int unsigned CNT_W = 17;
  localparam logic [CNT_W-1:0] CNT_MAX = 17'h1FFFF;
  localparam logic [CNT_W-1:0] LIMIT_BIAS = 17'd4;
  localparam logic [7:0] FILL_CHAR = 8'h20;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_LIT,
    CMD_MATCH,
    CMD_STATUS
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e kind;
    logic [7:0] lit;
    logic [5:0] len_m1;
    logic [WIN_AW-1:0] src;
    logic stream_end;
    logic size_ok;
    logic restart;
  } cmd_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic in_last;
  } in_item_t;

  typedef struct packed {
    logic has_data;
    logic [7:0] out_byte;
    logic run_last;
    logic stream_end;
    logic size_ok;
  } out_item_t;

endpackage

/* sv/lzd_stream_if.sv */
interface lzd_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/lzd_front.sv */
module lzd_front import lzd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  lzd_stream_if.sink in_i,
  input  logic q_full_i,
  output logic q_push_o,
  output cmd_t q_cmd_o
);

  typedef enum logic [2:0] {
    PH_H0,
    PH_H1,
    PH_H2,
    PH_H3,
    PH_ITEM,
    PH_LIT,
    PH_MHI,
    PH_MLO
  } phase_e;

  phase_e phase_q, phase_d;
  logic [15:0] exp_q, exp_d;
  logic [CNT_W-1:0] lim_q, lim_d;
  logic [CNT_W-1:0] ic_q, ic_d;
  logic [CNT_W-1:0] oc_q, oc_d;
  logic [6:0] flag_q, flag_d;
  logic [2:0] left_q, left_d;
  logic [7:0] mhi_q, mhi_d;
  logic fin_q, fin_d;

  logic accept;
  logic [7:0] in_b;
  logic last;
  logic item_done;
  logic emit_lit;
  logic emit_match;
  logic ended;
  logic [CNT_W-1:0] ic_new;
  logic [CNT_W-1:0] oc_new;
  logic [6:0] nbytes;
  logic [CNT_W:0] oc_sum;

  assign in_i.ready = !q_full_i;
  assign accept = in_i.valid && !q_full_i;
  assign in_b = in_i.data.in_byte;
  assign last = in_i.data.in_last;

  always_comb begin
    phase_d = phase_q;
    exp_d = exp_q;
    lim_d = lim_q;
    ic_d = ic_q;
    oc_d = oc_q;
    flag_d = flag_q;
    left_d = left_q;
    mhi_d = mhi_q;
    fin_d = fin_q;
    item_done = 1'b0;
    emit_lit = 1'b0;
    emit_match = 1'b0;
    ended = 1'b0;
    ic_new = (ic_q == CNT_MAX) ? ic_q : ic_q + 17'd1;

    if (accept && !fin_q) begin
      ic_d = ic_new;
      case (phase_q)
        PH_H0: begin
          exp_d = {in_b, 8'h00};
          phase_d = PH_H1;
        end
        PH_H1: begin
          exp_d = {exp_q[15:8], in_b};
          phase_d = PH_H2;
        end
        PH_H2: begin
          lim_d = {1'b0, in_b, 8'h00};
          phase_d = PH_H3;
        end
        PH_H3: begin
          lim_d = {1'b0, lim_q[15:8], in_b} + LIMIT_BIAS;
          phase_d = PH_ITEM;
          item_done = 1'b1;
        end
        PH_ITEM: begin
          if (left_q == 3'd0) begin
            // fresh descriptor, first flag used right away
            flag_d = in_b[7:1];
            left_d = 3'd7;
            phase_d = in_b[0] ? PH_LIT : PH_MHI;
          end else begin
            flag_d = {1'b0, flag_q[6:1]};
            left_d = left_q - 3'd1;
            if (flag_q[0]) begin
              emit_lit = 1'b1;
              item_done = 1'b1;
            end else begin
              mhi_d = in_b;
              phase_d = PH_MLO;
            end
          end
        end
        PH_LIT: begin
          emit_lit = 1'b1;
          item_done = 1'b1;
          phase_d = PH_ITEM;
        end
        PH_MHI: begin
          mhi_d = in_b;
          phase_d = PH_MLO;
        end
        PH_MLO: begin
          emit_match = 1'b1;
          item_done = 1'b1;
          phase_d = PH_ITEM;
        end
        default: begin
          phase_d = PH_H0;
        end
      endcase
    end

    nbytes = emit_match ? ({1'b0, mhi_q[7:2]} + 7'd1) : (emit_lit ? 7'd1 : 7'd0);
    oc_sum = {1'b0, oc_q} + {11'd0, nbytes};
    oc_new = oc_sum[CNT_W] ? CNT_MAX : oc_sum[CNT_W-1:0];

    if (accept && !fin_q) begin
      oc_d = oc_new;
      if (item_done && ((oc_new >= {1'b0, exp_d}) || (ic_new >= lim_d))) begin
        ended = 1'b1;
      end
      if (last) begin
        ended = 1'b1;
      end
      fin_d = ended;
    end

    if (emit_lit) begin
      q_cmd_o.kind = CMD_LIT;
    end else if (emit_match) begin
      q_cmd_o.kind = CMD_MATCH;
    end else if (ended) begin
      q_cmd_o.kind = CMD_STATUS;
    end else begin
      q_cmd_o.kind = CMD_NONE;
    end
    q_cmd_o.lit = in_b;
    q_cmd_o.len_m1 = mhi_q[7:2];
    q_cmd_o.src = {mhi_q[1:0], in_b};
    q_cmd_o.stream_end = ended;
    q_cmd_o.size_ok = ended && (oc_new == {1'b0, exp_d});
    q_cmd_o.restart = last;
    q_push_o = accept && ((q_cmd_o.kind != CMD_NONE) || last);

    // new stream after the final byte
    if (accept && last) begin
      phase_d = PH_H0;
      exp_d = '0;
      lim_d = '0;
      ic_d = '0;
      oc_d = '0;
      flag_d = '0;
      left_d = '0;
      mhi_d = '0;
      fin_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_H0;
      exp_q <= '0;
      lim_q <= '0;
      ic_q <= '0;
      oc_q <= '0;
      flag_q <= '0;
      left_q <= '0;
      mhi_q <= '0;
      fin_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      exp_q <= exp_d;
      lim_q <= lim_d;
      ic_q <= ic_d;
      oc_q <= oc_d;
      flag_q <= flag_d;
      left_q <= left_d;
      mhi_q <= mhi_d;
      fin_q <= fin_d;
    end
  end

endmodule

/* sv/lzd_cmd_fifo.sv */
module lzd_cmd_fifo import lzd_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t pop_cmd_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned LVL_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [LVL_W-1:0] FULL_LVL = LVL_W'(DEPTH);

  cmd_t mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [LVL_W-1:0] lvl_q, lvl_d;
  logic do_push;
  logic do_pop;

  assign full_o = (lvl_q == FULL_LVL);
  assign empty_o = (lvl_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign pop_cmd_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    lvl_d = lvl_q;
    if (do_push) begin
      wptr_d = (wptr_q == LAST_PTR) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LAST_PTR) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      lvl_d = lvl_q + 1'b1;
    end else if (do_pop && !do_push) begin
      lvl_d = lvl_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      lvl_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      lvl_q <= lvl_d;
    end
  end

endmodule

/* sv/lzd_back.sv */
module lzd_back import lzd_pkg::*; #(
  parameter int unsigned START_POS = 960
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_empty_i,
  input  cmd_t q_cmd_i,
  output logic q_pop_o,
  lzd_stream_if.source out_o
);

  localparam logic [WIN_AW-1:0] START_W = WIN_AW'(START_POS);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WIN_SIZE);

  typedef enum logic {
    S_IDLE,
    S_COPY
  } state_e;

  logic [7:0] ring_q [WIN_SIZE];
  logic [7:0] rdata_q;

  state_e state_q, state_d;
  logic [WIN_AW-1:0] wpos_q, wpos_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [WIN_AW-1:0] src_q, src_d;
  logic [5:0] cnt_q, cnt_d;
  logic hit_q, hit_d;
  logic fwd_q, fwd_d;
  logic [7:0] fwd_byte_q, fwd_byte_d;
  logic end_q, end_d;
  logic ok_q, ok_d;
  logic rst_ring_q, rst_ring_d;
  logic ov_q, ov_d;
  out_item_t out_q, out_d;

  logic out_free;
  logic needs_out;
  logic rd_en;
  logic [WIN_AW-1:0] rd_addr;
  logic wr_en;
  logic [7:0] wr_byte;
  logic [7:0] cur_byte;
  logic [WIN_AW-1:0] nxt_src;
  logic [FILL_W-1:0] fill_inc;

  // ring slot holds real data once the fill count has passed it
  function automatic logic written(input logic [WIN_AW-1:0] addr,
                                   input logic [FILL_W-1:0] fill);
    logic [WIN_AW-1:0] off;
    off = addr - START_W;
    return {1'b0, off} < fill;
  endfunction

  assign out_free = !ov_q || out_o.ready;
  assign needs_out = (q_cmd_i.kind == CMD_LIT) || (q_cmd_i.kind == CMD_STATUS);
  assign q_pop_o = (state_q == S_IDLE) && !q_empty_i && (!needs_out || out_free);
  assign cur_byte = fwd_q ? fwd_byte_q : (hit_q ? rdata_q : FILL_CHAR);
  assign nxt_src = src_q + 1'b1;
  assign fill_inc = (fill_q == FILL_MAX) ? fill_q : fill_q + 1'b1;
  assign out_o.valid = ov_q;
  assign out_o.data = out_q;

  always_comb begin
    state_d = state_q;
    wpos_d = wpos_q;
    fill_d = fill_q;
    src_d = src_q;
    cnt_d = cnt_q;
    hit_d = hit_q;
    fwd_d = fwd_q;
    fwd_byte_d = fwd_byte_q;
    end_d = end_q;
    ok_d = ok_q;
    rst_ring_d = rst_ring_q;
    ov_d = ov_q && !out_o.ready;
    out_d = out_q;
    rd_en = 1'b0;
    rd_addr = src_q;
    wr_en = 1'b0;
    wr_byte = cur_byte;

    case (state_q)
      S_IDLE: begin
        if (q_pop_o) begin
          case (q_cmd_i.kind)
            CMD_LIT: begin
              wr_en = 1'b1;
              wr_byte = q_cmd_i.lit;
              wpos_d = wpos_q + 1'b1;
              fill_d = fill_inc;
              ov_d = 1'b1;
              out_d.has_data = 1'b1;
              out_d.out_byte = q_cmd_i.lit;
              out_d.run_last = 1'b1;
              out_d.stream_end = q_cmd_i.stream_end;
              out_d.size_ok = q_cmd_i.size_ok;
            end
            CMD_STATUS: begin
              ov_d = 1'b1;
              out_d.has_data = 1'b0;
              out_d.out_byte = 8'h00;
              out_d.run_last = 1'b1;
              out_d.stream_end = q_cmd_i.stream_end;
              out_d.size_ok = q_cmd_i.size_ok;
            end
            CMD_MATCH: begin
              rd_en = 1'b1;
              rd_addr = q_cmd_i.src;
              src_d = q_cmd_i.src;
              cnt_d = q_cmd_i.len_m1;
              hit_d = written(q_cmd_i.src, fill_q);
              fwd_d = 1'b0;
              end_d = q_cmd_i.stream_end;
              ok_d = q_cmd_i.size_ok;
              rst_ring_d = q_cmd_i.restart;
              state_d = S_COPY;
            end
            default: begin
            end
          endcase
          if (q_cmd_i.restart && (q_cmd_i.kind != CMD_MATCH)) begin
            wpos_d = START_W;
            fill_d = '0;
          end
        end
      end
      S_COPY: begin
        if (out_free) begin
          wr_en = 1'b1;
          wpos_d = wpos_q + 1'b1;
          fill_d = fill_inc;
          ov_d = 1'b1;
          out_d.has_data = 1'b1;
          out_d.out_byte = cur_byte;
          out_d.run_last = (cnt_q == 6'd0);
          out_d.stream_end = (cnt_q == 6'd0) && end_q;
          out_d.size_ok = (cnt_q == 6'd0) && ok_q;
          if (cnt_q == 6'd0) begin
            state_d = S_IDLE;
            if (rst_ring_q) begin
              wpos_d = START_W;
              fill_d = '0;
            end
          end else begin
            cnt_d = cnt_q - 6'd1;
            src_d = nxt_src;
            rd_en = 1'b1;
            rd_addr = nxt_src;
            hit_d = written(nxt_src, fill_inc);
            // next source is the slot written this cycle
            fwd_d = (nxt_src == wpos_q);
            fwd_byte_d = cur_byte;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_q[wpos_q] <= wr_byte;
    end
    if (rd_en) begin
      rdata_q <= ring_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wpos_q <= START_W;
      fill_q <= '0;
      src_q <= '0;
      cnt_q <= '0;
      hit_q <= 1'b0;
      fwd_q <= 1'b0;
      fwd_byte_q <= '0;
      end_q <= 1'b0;
      ok_q <= 1'b0;
      rst_ring_q <= 1'b0;
      ov_q <= 1'b0;
      out_q <= '0;
    end else begin
      state_q <= state_d;
      wpos_q <= wpos_d;
      fill_q <= fill_d;
      src_q <= src_d;
      cnt_q <= cnt_d;
      hit_q <= hit_d;
      fwd_q <= fwd_d;
      fwd_byte_q <= fwd_byte_d;
      end_q <= end_d;
      ok_q <= ok_d;
      rst_ring_q <= rst_ring_d;
      ov_q <= ov_d;
      out_q <= out_d;
    end
  end

  a_copy_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COPY && !out_free) |=> (state_q == S_COPY && $stable(cnt_q)
      && $stable(src_q)))
    else $error("copy advanced while output stalled");

  a_copy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COPY && out_free && cnt_q == 6'd0) |=>
      (state_q == S_IDLE && ov_q && out_q.run_last))
    else $error("last copy byte not marked");

  a_status_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_q.has_data) |-> (out_q.stream_end && out_q.run_last))
    else $error("status result without stream end");

  a_empty_ring_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == '0) |-> (wpos_q == START_W))
    else $error("write position moved with empty ring");

endmodule

/* sv/lzss_1k_window_decoder.sv */
// channel  dir  payload                                          request moves
// in_i     in   in_byte[7:0], in_last                            one compressed byte
// out_o    out  has_data, out_byte[7:0], run_last, stream_end,   one decoded byte
//               size_ok                                          or a status word
// parser takes one byte per cycle while the command queue has room
// ring engine: literal or status sent on pop, match copied byte by byte (one ring read port)
// ring contents after reset or a stream's last input byte are tracked by a fill count, no clearing pass
// a stalled output holds the ring engine; the queue then fills and lowers in_i.ready
module lzss_1k_window_decoder import lzd_pkg::*; #(
  parameter int unsigned START_POS = 960,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  lzd_stream_if.sink in_i,
  lzd_stream_if.source out_o
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  lzd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_cmd_o  (push_cmd)
  );

  lzd_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .pop_cmd_o  (pop_cmd)
  );

  lzd_back #(
    .START_POS (START_POS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_cmd_i   (pop_cmd),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

/* tb/sv/lzd_checker.sv */
module lzd_result_checker import lzd_pkg::*; #(
  parameter int unsigned START_POS = 960
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_data_i,
  output int        errors_o,
  output int        pending_o
);

  localparam logic [WIN_AW-1:0] RING_START = WIN_AW'(START_POS);

  typedef enum logic [2:0] {
    PH_SIZE_HI,
    PH_SIZE_LO,
    PH_LIMIT_HI,
    PH_LIMIT_LO,
    PH_ITEM,
    PH_LITERAL,
    PH_MATCH_HI,
    PH_MATCH_LO
  } parse_phase_e;

  logic [7:0] ring_mem [WIN_SIZE];
  logic [WIN_AW-1:0] wr_pos;
  parse_phase_e phase;
  logic [15:0] size_hdr;
  logic [CNT_W-1:0] in_limit;
  logic [CNT_W-1:0] in_cnt;
  logic [CNT_W-1:0] out_cnt;
  logic [7:0] flag_bits;
  logic [3:0] flag_cnt;
  logic [7:0] match_hi;
  logic stopped;

  out_item_t decoded_q[$];
  int mismatches = 0;

  task automatic restart_stream();
    for (int i = 0; i < WIN_SIZE; i++) ring_mem[i] = FILL_CHAR;
    wr_pos = RING_START;
    phase = PH_SIZE_HI;
    size_hdr = '0;
    in_limit = '0;
    in_cnt = '0;
    out_cnt = '0;
    flag_bits = '0;
    flag_cnt = '0;
    match_hi = '0;
    stopped = 1'b0;
  endtask

  task automatic emit_decoded(input logic [7:0] b);
    ring_mem[wr_pos] = b;
    wr_pos = wr_pos + 1'b1;
    if (out_cnt != CNT_MAX) out_cnt = out_cnt + 1'b1;
    decoded_q.push_back('{has_data: 1'b1, out_byte: b, run_last: 1'b0,
                          stream_end: 1'b0, size_ok: 1'b0});
  endtask

  task automatic decode_byte(input in_item_t it);
    int first;
    int last_idx;
    logic item_done;
    logic ended;
    logic flag;
    logic [5:0] len_m1;
    logic [WIN_AW-1:0] src;
    first = decoded_q.size();
    item_done = 1'b0;
    ended = 1'b0;
    if (!stopped) begin
      if (in_cnt != CNT_MAX) in_cnt = in_cnt + 1'b1;
      case (phase)
        PH_SIZE_HI: begin
          size_hdr = {it.in_byte, 8'h00};
          phase = PH_SIZE_LO;
        end
        PH_SIZE_LO: begin
          size_hdr[7:0] = it.in_byte;
          phase = PH_LIMIT_HI;
        end
        PH_LIMIT_HI: begin
          in_limit = {1'b0, it.in_byte, 8'h00};
          phase = PH_LIMIT_LO;
        end
        PH_LIMIT_LO: begin
          in_limit = {1'b0, in_limit[15:8], it.in_byte} + LIMIT_BIAS;
          phase = PH_ITEM;
          item_done = 1'b1;
        end
        PH_ITEM: begin
          if (flag_cnt == 0) begin
            flag = it.in_byte[0];
            flag_bits = {1'b0, it.in_byte[7:1]};
            flag_cnt = 4'd7;
            phase = flag ? PH_LITERAL : PH_MATCH_HI;
          end else begin
            flag = flag_bits[0];
            flag_bits = flag_bits >> 1;
            flag_cnt = flag_cnt - 1'b1;
            if (flag) begin
              emit_decoded(it.in_byte);
              item_done = 1'b1;
            end else begin
              match_hi = it.in_byte;
              phase = PH_MATCH_LO;
            end
          end
        end
        PH_LITERAL: begin
          emit_decoded(it.in_byte);
          phase = PH_ITEM;
          item_done = 1'b1;
        end
        PH_MATCH_HI: begin
          match_hi = it.in_byte;
          phase = PH_MATCH_LO;
        end
        default: begin
          len_m1 = match_hi[7:2];
          src = {match_hi[1:0], it.in_byte};
          for (int i = 0; i <= int'(len_m1); i++) begin
            emit_decoded(ring_mem[src]);
            src = src + 1'b1;
          end
          phase = PH_ITEM;
          item_done = 1'b1;
        end
      endcase
      if (item_done && (out_cnt >= {1'b0, size_hdr} || in_cnt >= in_limit)) begin
        stopped = 1'b1;
        ended = 1'b1;
      end
      if (it.in_last && !stopped) begin
        stopped = 1'b1;
        ended = 1'b1;
      end
    end
    if (ended) begin
      if (decoded_q.size() == first) begin
        decoded_q.push_back('{has_data: 1'b0, out_byte: 8'h00, run_last: 1'b0,
                              stream_end: 1'b0, size_ok: 1'b0});
      end
      last_idx = decoded_q.size() - 1;
      decoded_q[last_idx].stream_end = 1'b1;
      decoded_q[last_idx].size_ok = (out_cnt == {1'b0, size_hdr});
    end
    if (decoded_q.size() > first) decoded_q[decoded_q.size() - 1].run_last = 1'b1;
    if (it.in_last) restart_stream();
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (!rst_ni) begin
      restart_stream();
      decoded_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (decoded_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: expected none, actual data=%0b byte=%h",
                   $time, out_data_i.has_data, out_data_i.out_byte);
        end else begin
          want = decoded_q.pop_front();
          if (out_data_i !== want) begin
            mismatches++;
            $display({"%0t: result mismatch: expected data=%0b byte=%h run_last=%0b",
                      " end=%0b size_ok=%0b, actual data=%0b byte=%h run_last=%0b",
                      " end=%0b size_ok=%0b"}, $time,
                     want.has_data, want.out_byte, want.run_last, want.stream_end,
                     want.size_ok, out_data_i.has_data, out_data_i.out_byte,
                     out_data_i.run_last, out_data_i.stream_end, out_data_i.size_ok);
          end
        end
      end
      if (in_valid_i && in_ready_i) decode_byte(in_data_i);
    end
    errors_o <= mismatches;
    pending_o <= decoded_q.size();
  end

endmodule

/* tb/sv/testbench.sv */
module testbench;
  import lzd_pkg::*;

  localparam int TOTAL_ITEMS = 480;
  localparam int CALM_FROM = 420;
  localparam int QUIET_LIMIT = 3000;

  logic clk_i = 1'b0;
  logic rst_ni;

  lzd_stream_if #(.T(in_item_t)) in_bus ();
  lzd_stream_if #(.T(out_item_t)) out_bus ();

  int errors;
  int pending;
  int quiet_cycles = 0;
  int sent_items;
  bit idle_on;
  bit drained_mid;
  logic [7:0] stream_q[$];

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  lzss_1k_window_decoder u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  lzd_result_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_bus.valid),
    .in_ready_i  (in_bus.ready),
    .in_data_i   (in_bus.data),
    .out_valid_i (out_bus.valid),
    .out_ready_i (out_bus.ready),
    .out_data_i  (out_bus.data),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  // watchdog on both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // output stalls in random bursts while idle_on is set
  initial begin
    int hold;
    hold = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
        out_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(0, 2);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.data <= '{in_byte: b, in_last: last};
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
  endtask

  task automatic send_stream();
    for (int i = 0; i < stream_q.size(); i++) begin
      send_byte(stream_q[i], i == stream_q.size() - 1);
    end
    stream_q.delete();
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // descriptor-coded stream with random literals and matches
  task automatic make_coded_stream(input bit cut);
    logic [7:0] body[$];
    int target;
    int produced;
    int flag_no;
    int desc_idx;
    int len;
    int keep;
    logic [WIN_AW-1:0] src;
    logic [15:0] hsize;
    logic [15:0] clen;
    target = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 300) : $urandom_range(1, 40);
    produced = 0;
    flag_no = 8;
    desc_idx = 0;
    while (produced < target) begin
      if (flag_no == 8) begin
        body.push_back(8'h00);
        desc_idx = body.size() - 1;
        flag_no = 0;
      end
      if ($urandom_range(0, 2) == 0) begin
        body[desc_idx] = body[desc_idx] | (8'h01 << flag_no);
        body.push_back(8'($urandom()));
        produced++;
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
        if ($urandom_range(0, 2) == 0) src = WIN_AW'($urandom());
        else src = WIN_AW'(960 + produced - $urandom_range(1, 16));
        body.push_back({6'(len - 1), src[9:8]});
        body.push_back(src[7:0]);
        produced += len;
      end
      flag_no++;
    end
    case ($urandom_range(0, 5))
      0: hsize = 16'(target);
      1: hsize = 16'(produced + $urandom_range(1, 4));
      default: hsize = 16'(produced);
    endcase
    case ($urandom_range(0, 7))
      0: clen = 16'($urandom_range(0, body.size()));
      1: clen = 16'hFFFF;
      default: clen = 16'(body.size());
    endcase
    if (cut) begin
      keep = $urandom_range(0, body.size() - 1);
      while (body.size() > keep) void'(body.pop_back());
    end
    stream_q = '{hsize[15:8], hsize[7:0], clen[15:8], clen[7:0]};
    foreach (body[i]) stream_q.push_back(body[i]);
    sent_items += 4 + body.size();
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) stream_q.push_back(8'($urandom()));
    end
  endtask

  initial begin
    int noise_len;
    rst_ni <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.data <= '0;
    idle_on = 1'b1;
    drained_mid = 1'b0;
    sent_items = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty output, stop right after header, trailing byte ignored
    stream_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hAA};
    send_stream();
    // literal then longest overlapping match from the fill, overshoot
    stream_q = '{8'h00, 8'h03, 8'h00, 8'h05, 8'h01, 8'hFF, 8'hFF, 8'hBF, 8'h00};
    send_stream();
    // maximal header, last byte inside a match
    stream_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00};
    send_stream();
    // last byte inside the header
    stream_q = '{8'h12, 8'h34};
    send_stream();
    // compressed limit reached on a literal that is also last
    stream_q = '{8'h00, 8'h10, 8'h00, 8'h01, 8'h01, 8'h00};
    send_stream();
    wait_drained();

    while (sent_items < TOTAL_ITEMS) begin
      if (!drained_mid && sent_items >= TOTAL_ITEMS / 2) begin
        wait_drained();
        drained_mid = 1'b1;
      end
      if (sent_items >= CALM_FROM) idle_on = 1'b0;
      case ($urandom_range(0, 9))
        0: begin
          noise_len = $urandom_range(1, 12);
          repeat (noise_len) stream_q.push_back(8'($urandom()));
          sent_items += noise_len;
        end
        1: make_coded_stream(1'b1);
        default: make_coded_stream(1'b0);
      endcase
      send_stream();
    end
    idle_on = 1'b0;
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
